[design/krt_pkg.sv]
// ----------------------------------------------------------------------------
// krt_pkg
// item types, record type, opcode and status codes for the keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int unsigned RESULT_CAP = 64;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_FIND_ID  = 3'd1;
  localparam logic [2:0] OP_FIND_VAL = 3'd2;
  localparam logic [2:0] OP_DELETE   = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_NONE  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key_id;
    logic [63:0] entry_value;
    logic [5:0]  position;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  found_position;
    logic [31:0] found_id;
    logic [63:0] found_value;
    logic [6:0]  entry_count;
    logic        last_result;
  } rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] value;
  } rec_t;

endpackage

[design/krt_mem.sv]
// ----------------------------------------------------------------------------
// krt_mem
// record store: one write port, one registered read port
// ----------------------------------------------------------------------------
module krt_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output krt_pkg::rec_t  rd_data,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  krt_pkg::rec_t  wr_data
);
  import krt_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/krt_ctrl.sv]
// ----------------------------------------------------------------------------
// krt_ctrl
// sequencer: scans the record store, appends, swap-removes and reads records
// ----------------------------------------------------------------------------
module krt_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  krt_pkg::req_t  req,
  input  logic           out_free,
  output logic           emit,
  output krt_pkg::rsp_t  emit_item,
  output logic           rd_en,
  output logic [AW-1:0]  rd_addr,
  input  krt_pkg::rec_t  rd_data,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output krt_pkg::rec_t  wr_data
);
  import krt_pkg::*;

  localparam int unsigned CMPW = (CW > 6) ? CW : 6;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DELRD = 3'd3;
  localparam logic [2:0] S_DELWR = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] issue_idx, issue_idx_next;
  logic          rd_vld, rd_vld_next;
  logic          pend, pend_next;
  logic [6:0]    nmatch, nmatch_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic [AW-1:0] hit_idx, hit_idx_next;
  logic [2:0]    op, op_next;
  logic [31:0]   key, key_next;
  logic [63:0]   val, val_next;
  rsp_t          res, res_next;

  logic          do_issue;
  logic          id_hit;
  logic          val_hit;
  logic          scan_done;
  logic [CW-1:0] tail;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;

  function automatic rsp_t hit_item(logic [2:0] st, logic [AW-1:0] idx, rec_t r, logic last);
    rsp_t o;
    o                = '0;
    o.status         = st;
    o.found_position = 6'(idx);
    o.found_id       = r.id;
    o.found_value    = r.value;
    o.last_result    = last;
    return o;
  endfunction

  function automatic rsp_t miss_item(logic [2:0] st);
    rsp_t o;
    o             = '0;
    o.status      = st;
    o.last_result = 1'b1;
    return o;
  endfunction

  assign req_ready = (state == S_IDLE);
  assign id_hit    = (rd_data.id == key);
  assign val_hit   = (rd_data.value == val);
  assign scan_done = !rd_vld && (issue_idx == count);
  assign tail      = count - CW'(1);
  assign pos_ext   = CMPW'(req.position);
  assign cnt_ext   = CMPW'(count);

  always_comb begin
    state_next     = state;
    count_next     = count;
    issue_idx_next = issue_idx;
    rd_vld_next    = 1'b0;
    pend_next      = pend;
    nmatch_next    = nmatch;
    rd_idx_next    = rd_idx;
    hit_idx_next   = hit_idx;
    op_next        = op;
    key_next       = key;
    val_next       = val;
    res_next       = res;
    do_issue       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = issue_idx[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = count[AW-1:0];
    wr_data        = '{id: key, value: val};
    emit           = 1'b0;
    emit_item      = res;
    emit_item.entry_count = 7'(count);

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next        = req.opcode;
          key_next       = req.key_id;
          val_next       = req.entry_value;
          pend_next      = 1'b0;
          nmatch_next    = '0;
          issue_idx_next = '0;
          case (req.opcode) inside
            OP_ADD, OP_FIND_ID, OP_FIND_VAL, OP_DELETE: begin
              state_next = S_SCAN;
            end
            OP_READ: begin
              if (pos_ext < cnt_ext) begin
                rd_en       = 1'b1;
                rd_addr     = pos_ext[AW-1:0];
                rd_idx_next = pos_ext[AW-1:0];
                state_next  = S_READ;
              end else begin
                res_next   = miss_item(ST_RANGE);
                state_next = S_EMIT;
              end
            end
            default: begin
              res_next   = miss_item(ST_NONE);
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_vld && (op == OP_FIND_VAL) && val_hit) begin
          if (pend && !out_free) begin
            rd_vld_next = 1'b1;
          end else begin
            emit        = pend;
            res_next    = hit_item(ST_OK, rd_idx, rd_data, 1'b0);
            pend_next   = 1'b1;
            nmatch_next = nmatch + 7'd1;
            if (nmatch == 7'(RESULT_CAP - 1)) begin
              res_next.last_result = 1'b1;
              state_next           = S_EMIT;
            end else begin
              do_issue = 1'b1;
            end
          end
        end else if (rd_vld && (op != OP_FIND_VAL) && id_hit) begin
          hit_idx_next = rd_idx;
          res_next     = hit_item((op == OP_ADD) ? ST_DUP : ST_OK, rd_idx, rd_data, 1'b1);
          state_next   = (op == OP_DELETE) ? S_DELRD : S_EMIT;
        end else if (scan_done) begin
          state_next = S_EMIT;
          case (op)
            OP_ADD: begin
              if (count == CW'(DEPTH)) begin
                res_next = miss_item(ST_FULL);
              end else begin
                wr_en      = 1'b1;
                res_next   = hit_item(ST_OK, count[AW-1:0], '{id: key, value: val}, 1'b1);
                count_next = count + CW'(1);
              end
            end
            OP_FIND_VAL: begin
              if (pend) begin
                res_next.last_result = 1'b1;
              end else begin
                res_next = miss_item(ST_NONE);
              end
            end
            default: begin
              res_next = miss_item(ST_NONE);
            end
          endcase
        end else begin
          do_issue = 1'b1;
        end
        if (do_issue && (issue_idx != count)) begin
          rd_en          = 1'b1;
          rd_addr        = issue_idx[AW-1:0];
          rd_idx_next    = issue_idx[AW-1:0];
          issue_idx_next = issue_idx + CW'(1);
          rd_vld_next    = 1'b1;
        end
      end
      S_READ: begin
        res_next   = hit_item(ST_OK, rd_idx, rd_data, 1'b1);
        state_next = S_EMIT;
      end
      S_DELRD: begin
        rd_en      = 1'b1;
        rd_addr    = tail[AW-1:0];
        state_next = S_DELWR;
      end
      S_DELWR: begin
        wr_en      = 1'b1;
        wr_addr    = hit_idx;
        wr_data    = rd_data;
        count_next = tail;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_vld <= 1'b0;
      pend   <= 1'b0;
      nmatch <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_vld <= rd_vld_next;
      pend   <= pend_next;
      nmatch <= nmatch_next;
    end
  end

  always_ff @(posedge clk) begin
    issue_idx <= issue_idx_next;
    rd_idx    <= rd_idx_next;
    hit_idx   <= hit_idx_next;
    op        <= op_next;
    key       <= key_next;
    val       <= val_next;
    res       <= res_next;
  end

endmodule

[design/keyed_record_table.sv]
// ----------------------------------------------------------------------------
// keyed_record_table
// dense table of id/value records with add, find, swap-remove and read
// ----------------------------------------------------------------------------
// usage:
//   req/req_valid/req_ready carries one operation item; rsp/rsp_valid/
//   rsp_ready returns its result items through an output register.
//   find by value returns every match in ascending position order, at most
//   64, and sets last_result on the final one; all other operations return
//   one item with last_result set.
// operation flow:
//   read fetches the record at the given position; out of range or an unknown
//   opcode answers without a store read. add, find by id, find by value
//   and delete scan the held records, one store read per cycle unless a
//   value search pauses; delete then moves the tail record into the hole.
//   one operation is in flight at a time; req_ready is high only when idle.
// reset:
//   rst clears the record count to zero; the store contents are don't-care.
// stall:
//   a stalled rsp_ready holds the output register, and a value search
//   pauses its scan until the pending match can be handed over.
// ----------------------------------------------------------------------------
module keyed_record_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  krt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output krt_pkg::rsp_t rsp
);
  import krt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          out_free;
  logic          emit;
  rsp_t          emit_item;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  rec_t          rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;

  assign out_free = !rsp_valid || rsp_ready;

  krt_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_free  (out_free),
    .emit      (emit),
    .emit_item (emit_item),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  krt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= emit_item;
    end
  end

endmodule

[design/krt_checker.sv]
// ----------------------------------------------------------------------------
// krt_checker
// port-level checks for the keyed record table
// ----------------------------------------------------------------------------
module krt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input krt_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input krt_pkg::rsp_t rsp
);
  import krt_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("new item accepted while previous one in progress");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) && (rsp.status != ST_DUP) |->
      rsp.found_id == '0 && rsp.found_value == '0 &&
      rsp.found_position == '0 && rsp.last_result)
    else $error("error result carries record fields or is not last");

endmodule

bind keyed_record_table krt_checker u_krt_checker (.*);

[bench/tb_keyed_record_table.sv]
// ----------------------------------------------------------------------------
// tb_keyed_record_table
// self-checking bench for the keyed record table: directed corner items, a
// full-table fill with one shared value, then random traffic biased toward
// held ids and a small value pool; results are predicted per accepted item
// and checked in order by a scoreboard, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_keyed_record_table;
  timeunit 1ns;
  timeprecision 1ps;

  import krt_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  class record_table_scoreboard;
    logic [31:0] held_ids [TABLE_DEPTH];
    logic [63:0] held_values [TABLE_DEPTH];
    int unsigned held_count;
    rsp_t        expected_results [$];
    int unsigned mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function void push_result(logic [2:0] st, int unsigned pos, logic [31:0] id,
                              logic [63:0] value, logic last);
      rsp_t r;
      r.status         = st;
      r.found_position = pos[5:0];
      r.found_id       = id;
      r.found_value    = value;
      r.entry_count    = held_count[6:0];
      r.last_result    = last;
      expected_results = {expected_results, r};
    endfunction

    function int id_position(logic [31:0] id);
      for (int i = 0; i < held_count; i++) begin
        if (held_ids[i] == id) begin
          return i;
        end
      end
      return -1;
    endfunction

    function logic [31:0] pick_held_id();
      if (held_count == 0) begin
        return $urandom;
      end
      return held_ids[$urandom_range(0, held_count - 1)];
    endfunction

    function void apply_op(req_t r);
      int          at;
      int unsigned tail;
      int unsigned hits;
      logic [31:0] gone_id;
      logic [63:0] gone_value;
      at = id_position(r.key_id);
      case (r.opcode)
        OP_ADD: begin
          if (at >= 0) begin
            push_result(ST_DUP, at, held_ids[at], held_values[at], 1'b1);
          end else if (held_count >= TABLE_DEPTH) begin
            push_result(ST_FULL, 0, '0, '0, 1'b1);
          end else begin
            held_ids[held_count]    = r.key_id;
            held_values[held_count] = r.entry_value;
            held_count++;
            push_result(ST_OK, held_count - 1, r.key_id, r.entry_value, 1'b1);
          end
        end
        OP_FIND_ID: begin
          if (at < 0) begin
            push_result(ST_NONE, 0, '0, '0, 1'b1);
          end else begin
            push_result(ST_OK, at, held_ids[at], held_values[at], 1'b1);
          end
        end
        OP_FIND_VAL: begin
          hits = 0;
          for (int i = 0; i < held_count && hits < RESULT_CAP; i++) begin
            if (held_values[i] == r.entry_value) begin
              push_result(ST_OK, i, held_ids[i], held_values[i], 1'b0);
              hits++;
            end
          end
          if (hits == 0) begin
            push_result(ST_NONE, 0, '0, '0, 1'b1);
          end else begin
            expected_results[expected_results.size() - 1].last_result = 1'b1;
          end
        end
        OP_DELETE: begin
          if (at < 0) begin
            push_result(ST_NONE, 0, '0, '0, 1'b1);
          end else begin
            gone_id         = held_ids[at];
            gone_value      = held_values[at];
            tail            = held_count - 1;
            held_ids[at]    = held_ids[tail];
            held_values[at] = held_values[tail];
            held_count      = tail;
            push_result(ST_OK, at, gone_id, gone_value, 1'b1);
          end
        end
        OP_READ: begin
          if (r.position < held_count) begin
            push_result(ST_OK, r.position, held_ids[r.position], held_values[r.position],
                        1'b1);
          end else begin
            push_result(ST_RANGE, 0, '0, '0, 1'b1);
          end
        end
        default: begin
          push_result(ST_NONE, 0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: st=%0d pos=%0d id=%h val=%h cnt=%0d last=%0b",
                 $time, got.status, got.found_position, got.found_id, got.found_value,
                 got.entry_count, got.last_result);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.found_position !== want.found_position ||
          got.found_id !== want.found_id || got.found_value !== want.found_value ||
          got.entry_count !== want.entry_count || got.last_result !== want.last_result) begin
        $display("%0t: mismatch expected st=%0d pos=%0d id=%h val=%h cnt=%0d last=%0b",
                 $time, want.status, want.found_position, want.found_id, want.found_value,
                 want.entry_count, want.last_result);
        $display("%0t:          actual   st=%0d pos=%0d id=%h val=%h cnt=%0d last=%0b",
                 $time, got.status, got.found_position, got.found_id, got.found_value,
                 got.entry_count, got.last_result);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req       = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        steady    = 1'b0;
  int unsigned cycle_count = 0;
  logic [63:0] value_pool [4];

  record_table_scoreboard sb = new();

  keyed_record_table #(
    .DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        sb.apply_op(req);
      end
      if (rsp_valid && rsp_ready) begin
        sb.check_result(rsp);
      end
    end
  end

  always @(negedge clk) begin
    rsp_ready = steady || ($urandom_range(0, 99) >= 34);
  end

  function automatic logic [63:0] any_value();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] some_value();
    if ($urandom_range(0, 9) < 7) begin
      return value_pool[$urandom_range(0, 3)];
    end
    return any_value();
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_op(logic [2:0] op, logic [31:0] id, logic [63:0] value,
                         logic [5:0] pos);
    while (!steady && $urandom_range(0, 99) < 34) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req.opcode      = op;
    req.key_id      = id;
    req.entry_value = value;
    req.position    = pos;
    req_valid       = 1'b1;
    do begin
      @(posedge clk);
    end while (!req_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [63:0] fill_value;
    int unsigned pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table
    send_op(OP_READ, '0, '0, 6'd0);
    send_op(OP_FIND_ID, '0, '0, '0);
    send_op(OP_FIND_VAL, '0, '0, '0);
    send_op(OP_DELETE, '0, '0, '0);
    // extremes, duplicate, multi-match value search
    send_op(OP_ADD, '0, '0, '0);
    send_op(OP_ADD, '1, '1, '1);
    send_op(OP_ADD, '0, 64'd5, '0);
    send_op(OP_ADD, 32'h1234_5678, '0, '0);
    send_op(OP_FIND_ID, '1, '0, '0);
    send_op(OP_FIND_VAL, '0, '0, '1);
    send_op(OP_READ, '0, '0, 6'd1);
    send_op(OP_READ, '0, '0, '1);
    send_op(OP_READ, '0, '0, 6'd3);
    for (int op = OP_READ + 1; op < 8; op++) begin
      send_op(op[2:0], '1, '1, '1);
    end
    // swap-remove from the front, then of the only record, then of a missing id
    send_op(OP_DELETE, '0, '0, '0);
    send_op(OP_READ, '0, '0, 6'd0);
    send_op(OP_DELETE, 32'h1234_5678, '0, '0);
    send_op(OP_DELETE, '1, '0, '0);
    send_op(OP_DELETE, '1, '0, '0);
    send_op(OP_FIND_VAL, '0, '1, '0);

    // hold off until the table is quiet
    req_valid = 1'b0;
    while (sb.expected_results.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);

    // fill the table with one shared value, no idling on either side
    fill_value = any_value();
    steady = 1'b1;
    while (sb.held_count < TABLE_DEPTH) begin
      send_op(OP_ADD, $urandom, fill_value, 6'($urandom_range(0, 63)));
    end
    send_op(OP_ADD, $urandom, any_value(), '0);
    send_op(OP_ADD, sb.pick_held_id(), any_value(), '0);
    send_op(OP_FIND_VAL, $urandom, fill_value, '0);
    send_op(OP_READ, $urandom, any_value(), '1);
    send_op(OP_FIND_ID, sb.pick_held_id(), any_value(), '0);
    send_op(OP_DELETE, sb.pick_held_id(), any_value(), '0);
    steady = 1'b0;
    send_op(OP_FIND_VAL, $urandom, fill_value, '0);

    value_pool[0] = fill_value;
    value_pool[1] = '0;
    value_pool[2] = '1;
    value_pool[3] = any_value();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_op(OP_ADD, ($urandom_range(0, 4) == 0) ? sb.pick_held_id() : $urandom,
                some_value(), 6'($urandom_range(0, 63)));
      end else if (pick < 40) begin
        send_op(OP_FIND_ID, ($urandom_range(0, 9) < 7) ? sb.pick_held_id() : $urandom,
                any_value(), 6'($urandom_range(0, 63)));
      end else if (pick < 55) begin
        send_op(OP_FIND_VAL, $urandom, some_value(), 6'($urandom_range(0, 63)));
      end else if (pick < 80) begin
        send_op(OP_DELETE, ($urandom_range(0, 3) != 0) ? sb.pick_held_id() : $urandom,
                any_value(), 6'($urandom_range(0, 63)));
      end else if (pick < 95) begin
        send_op(OP_READ, $urandom, any_value(),
                (sb.held_count > 0 && $urandom_range(0, 1) == 1) ?
                  6'($urandom_range(0, sb.held_count - 1)) : 6'($urandom_range(0, 63)));
      end else begin
        send_op(OP_READ + 3'($urandom_range(1, 3)), $urandom, any_value(),
                6'($urandom_range(0, 63)));
      end
    end

    req_valid = 1'b0;
    while (sb.expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
